// File: design/gps_pkg.sv
package gps_pkg;

  localparam int SqrtSteps = 33;
  localparam int RootW = 33;
  localparam int SumW = 65;
  localparam int RemW = 67;
  localparam int CubeW = 99;
  localparam int QuoW = 32;

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [15:0] attractor_x;
    logic signed [15:0] attractor_y;
    logic [31:0] strength;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic too_close;
  } out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } state_t;

  typedef struct packed {
    state_t st;
    logic neg_x;
    logic neg_y;
    logic [63:0] prod_x;
    logic [63:0] prod_y;
  } side_t;

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

endpackage

// File: design/gps_front.sv
module gps_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  gps_pkg::in_t    in_data,
  output logic            sum_valid,
  output logic [gps_pkg::SumW-1:0] sum,
  output gps_pkg::side_t  side
);

  logic                 s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic signed [32:0]   s1_dx_r, s1_dy_r;
  logic [31:0]          s1_str_r, s2_str_r;
  gps_pkg::state_t      s1_st_r, s2_st_r;
  logic [31:0]          s2_mag_x_r, s2_mag_y_r;
  logic                 s2_neg_x_r, s2_neg_y_r;
  logic [63:0]          s3_sq_x_r, s3_sq_y_r;
  gps_pkg::side_t       s3_side_r, s4_side_r;
  logic [gps_pkg::SumW-1:0] s4_sum_r;
  logic [32:0]          neg_dx, neg_dy;

  assign neg_dx = -s1_dx_r;
  assign neg_dy = -s1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // attractor minus sample, q17.16
      s1_dx_r <= {in_data.attractor_x[15], in_data.attractor_x, 16'b0}
               - {in_data.sample_x[31], in_data.sample_x};
      s1_dy_r <= {in_data.attractor_y[15], in_data.attractor_y, 16'b0}
               - {in_data.sample_y[31], in_data.sample_y};
      s1_str_r <= in_data.strength;
      s1_st_r.pos_x <= in_data.pos_x;
      s1_st_r.pos_y <= in_data.pos_y;
      s1_st_r.vel_x <= in_data.vel_x;
      s1_st_r.vel_y <= in_data.vel_y;

      s2_neg_x_r <= s1_dx_r[32];
      s2_neg_y_r <= s1_dy_r[32];
      s2_mag_x_r <= s1_dx_r[32] ? neg_dx[31:0] : s1_dx_r[31:0];
      s2_mag_y_r <= s1_dy_r[32] ? neg_dy[31:0] : s1_dy_r[31:0];
      s2_str_r <= s1_str_r;
      s2_st_r <= s1_st_r;

      s3_sq_x_r <= s2_mag_x_r * s2_mag_x_r;
      s3_sq_y_r <= s2_mag_y_r * s2_mag_y_r;
      s3_side_r.prod_x <= s2_mag_x_r * s2_str_r;
      s3_side_r.prod_y <= s2_mag_y_r * s2_str_r;
      s3_side_r.neg_x <= s2_neg_x_r;
      s3_side_r.neg_y <= s2_neg_y_r;
      s3_side_r.st <= s2_st_r;

      s4_sum_r <= {1'b0, s3_sq_x_r} + {1'b0, s3_sq_y_r};
      s4_side_r <= s3_side_r;
    end
  end

  assign sum_valid = s4_valid_r;
  assign sum = s4_sum_r;
  assign side = s4_side_r;

endmodule

// File: design/gps_sqrt.sv
module gps_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [gps_pkg::SumW-1:0] sum,
  input  gps_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [gps_pkg::RootW-1:0] root,
  output gps_pkg::side_t  out_side
);

  localparam int N = gps_pkg::SqrtSteps;

  logic                          vld_r  [N];
  logic [gps_pkg::RemW-1:0]      rem_r  [N];
  logic [gps_pkg::RootW-1:0]     root_r [N];
  gps_pkg::side_t                side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int B = N - 1 - i;
    logic                      vld_i;
    logic [gps_pkg::RemW-1:0]  rem_i, trial;
    logic [gps_pkg::RootW-1:0] root_i;
    gps_pkg::side_t            side_i;

    if (i == 0) begin : g_first
      assign vld_i = in_valid;
      assign rem_i = {{(gps_pkg::RemW-gps_pkg::SumW){1'b0}}, sum};
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i = vld_r[i-1];
      assign rem_i = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign side_i = side_r[i-1];
    end

    // (root + 2^b)^2 - root^2
    assign trial = ({{(gps_pkg::RemW-gps_pkg::RootW){1'b0}}, root_i} << (B + 1))
                 + (gps_pkg::RemW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_r[i] <= rem_i - trial;
          root_r[i] <= root_i | (gps_pkg::RootW'(1) << B);
        end else begin
          rem_r[i] <= rem_i;
          root_r[i] <= root_i;
        end
        side_r[i] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// File: design/gps_accel.sv
module gps_accel (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [gps_pkg::RootW-1:0] root,
  input  gps_pkg::side_t  in_side,
  output logic            out_valid,
  output gps_pkg::out_t   out_data
);

  localparam int CW = gps_pkg::CubeW;
  localparam int QW = gps_pkg::QuoW;

  typedef struct packed {
    gps_pkg::side_t side;
    logic           zero;
    logic           big_x;
    logic           big_y;
    logic [CW-1:0]  d;
    logic [CW-1:0]  rem_x;
    logic [CW-1:0]  rem_y;
    logic [QW-1:0]  q_x;
    logic [QW-1:0]  q_y;
  } div_t;

  logic                       t1_valid_r, t2_valid_r, t3_valid_r, t4_valid_r;
  logic [gps_pkg::RootW-1:0]  t1_r_r;
  logic [2*gps_pkg::RootW-1:0] t1_r2_r;
  logic [64:0]                t2_plo_r;
  logic [66:0]                t2_phi_r;
  logic [CW-1:0]              t3_d_r;
  gps_pkg::side_t             t1_side_r, t2_side_r, t3_side_r;
  logic                       t1_zero_r, t2_zero_r, t3_zero_r;
  div_t                       t4_r;

  logic                       dv_r [QW];
  div_t                       ds_r [QW];

  logic                       f1_valid_r, f2_valid_r, f3_valid_r;
  logic signed [31:0]         f1_acc_x_r, f1_acc_y_r;
  logic signed [31:0]         f2_vel_x_r, f2_vel_y_r;
  gps_pkg::state_t            f1_st_r, f2_st_r;
  logic                       f1_zero_r, f2_zero_r;
  gps_pkg::out_t              f3_out_r;
  div_t                       dlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r <= 1'b0;
      t2_valid_r <= 1'b0;
      t3_valid_r <= 1'b0;
      t4_valid_r <= 1'b0;
    end else if (en) begin
      t1_valid_r <= in_valid;
      t2_valid_r <= t1_valid_r;
      t3_valid_r <= t2_valid_r;
      t4_valid_r <= t3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r_r <= root;
      t1_r2_r <= root * root;
      t1_zero_r <= (root == '0);
      t1_side_r <= in_side;

      // r^3 from two partial products of r^2 * r
      t2_plo_r <= t1_r2_r[31:0] * t1_r_r;
      t2_phi_r <= t1_r2_r[65:32] * t1_r_r;
      t2_zero_r <= t1_zero_r;
      t2_side_r <= t1_side_r;

      t3_d_r <= {{(CW-65){1'b0}}, t2_plo_r} + {t2_phi_r, 32'b0};
      t3_zero_r <= t2_zero_r;
      t3_side_r <= t2_side_r;

      // quotient of at least 2^32 always saturates
      t4_r.side <= t3_side_r;
      t4_r.zero <= t3_zero_r;
      t4_r.d <= t3_d_r;
      t4_r.big_x <= {{(CW-64){1'b0}}, t3_side_r.prod_x} >= t3_d_r;
      t4_r.big_y <= {{(CW-64){1'b0}}, t3_side_r.prod_y} >= t3_d_r;
      t4_r.rem_x <= {{(CW-64){1'b0}}, t3_side_r.prod_x};
      t4_r.rem_y <= {{(CW-64){1'b0}}, t3_side_r.prod_y};
      t4_r.q_x <= '0;
      t4_r.q_y <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic          vld_i;
    div_t          cur, nxt;
    logic [CW:0]   sh_x, sh_y, df_x, df_y;

    if (j == 0) begin : g_first
      assign vld_i = t4_valid_r;
      assign cur = t4_r;
    end else begin : g_next
      assign vld_i = dv_r[j-1];
      assign cur = ds_r[j-1];
    end

    assign sh_x = {cur.rem_x, 1'b0};
    assign sh_y = {cur.rem_y, 1'b0};
    assign df_x = sh_x - {1'b0, cur.d};
    assign df_y = sh_y - {1'b0, cur.d};

    always_comb begin
      nxt = cur;
      if (sh_x >= {1'b0, cur.d}) begin
        nxt.rem_x = df_x[CW-1:0];
        nxt.q_x = {cur.q_x[QW-2:0], 1'b1};
      end else begin
        nxt.rem_x = sh_x[CW-1:0];
        nxt.q_x = {cur.q_x[QW-2:0], 1'b0};
      end
      if (sh_y >= {1'b0, cur.d}) begin
        nxt.rem_y = df_y[CW-1:0];
        nxt.q_y = {cur.q_y[QW-2:0], 1'b1};
      end else begin
        nxt.rem_y = sh_y[CW-1:0];
        nxt.q_y = {cur.q_y[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[j] <= nxt;
      end
    end
  end

  assign dlast = ds_r[QW-1];

  function automatic logic signed [31:0] signed_acc(input logic [QW-1:0] q,
                                                    input logic big,
                                                    input logic neg);
    logic [QW-1:0] m;
    m = -q;
    if (neg) begin
      signed_acc = (big || q > 32'h80000000) ? 32'sh80000000 : m;
    end else begin
      signed_acc = (big || q > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : q;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= dv_r[QW-1];
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_acc_x_r <= signed_acc(dlast.q_x, dlast.big_x, dlast.side.neg_x);
      f1_acc_y_r <= signed_acc(dlast.q_y, dlast.big_y, dlast.side.neg_y);
      f1_st_r <= dlast.side.st;
      f1_zero_r <= dlast.zero;

      f2_vel_x_r <= gps_pkg::sat_add32(f1_st_r.vel_x, f1_acc_x_r);
      f2_vel_y_r <= gps_pkg::sat_add32(f1_st_r.vel_y, f1_acc_y_r);
      f2_st_r <= f1_st_r;
      f2_zero_r <= f1_zero_r;

      if (f2_zero_r) begin
        f3_out_r.new_pos_x <= f2_st_r.pos_x;
        f3_out_r.new_pos_y <= f2_st_r.pos_y;
        f3_out_r.new_vel_x <= f2_st_r.vel_x;
        f3_out_r.new_vel_y <= f2_st_r.vel_y;
      end else begin
        f3_out_r.new_pos_x <= gps_pkg::sat_add32(f2_st_r.pos_x, f2_vel_x_r);
        f3_out_r.new_pos_y <= gps_pkg::sat_add32(f2_st_r.pos_y, f2_vel_y_r);
        f3_out_r.new_vel_x <= f2_vel_x_r;
        f3_out_r.new_vel_y <= f2_vel_y_r;
      end
      f3_out_r.too_close <= f2_zero_r;
    end
  end

  assign out_valid = f3_valid_r;
  assign out_data = f3_out_r;

endmodule

// File: design/gravity_particle_step.sv
// One particle/attractor interaction per cycle while the result is not stalled, fully pipelined:
// the offset and its squares are formed first, then a bit-per-stage square root, then r^3
// and the overflow check, then a bit-per-stage division per axis, and last the saturating
// velocity and position update. A stalled result freezes the whole pipeline; nothing is
// dropped.
module gravity_particle_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gps_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output gps_pkg::out_t  out_data
);

  logic                         en;
  logic                         sum_valid, root_valid;
  logic [gps_pkg::SumW-1:0]     sum;
  logic [gps_pkg::RootW-1:0]    root;
  gps_pkg::side_t               front_side, root_side;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  gps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .sum_valid (sum_valid),
    .sum       (sum),
    .side      (front_side)
  );

  gps_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sum_valid),
    .sum       (sum),
    .in_side   (front_side),
    .out_valid (root_valid),
    .root      (root),
    .out_side  (root_side)
  );

  gps_accel u_accel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (root_valid),
    .root      (root),
    .in_side   (root_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: design/gps_checker.sv
module gps_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input gps_pkg::out_t out_data
);

  // held result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // backpressure only comes from a held result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while pipeline frozen");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gravity_particle_step gps_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_gravity_particle_step.sv
`timescale 1ns / 1ps

module tb_gravity_particle_step;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  gps_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  gps_pkg::out_t out_data;

  gps_pkg::out_t expected_states[$];
  int mismatches;
  int cycles;
  bit idle_on;
  int out_stall_left;

  gravity_particle_step uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint gravity_accel(input longint d, input logic [31:0] s,
                                           input logic [255:0] r);
    logic [255:0] mag;
    logic [255:0] q;
    logic [255:0] lim;
    mag = (d < 0) ? 256'(-d) : 256'(d);
    lim = (d < 0) ? 256'h80000000 : 256'h7FFFFFFF;
    q = ((mag * 256'(s)) << 32) / (r * r * r);
    if (q > lim) q = lim;
    return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic gps_pkg::out_t gravity_step(input gps_pkg::in_t a);
    gps_pkg::out_t o;
    longint dx;
    longint dy;
    longint vx;
    longint vy;
    longint px;
    longint py;
    logic [255:0] mx;
    logic [255:0] my;
    logic [255:0] sum;
    logic [255:0] r;
    logic [255:0] t;
    dx = longint'(a.attractor_x) * 65536 - longint'(a.sample_x);
    dy = longint'(a.attractor_y) * 65536 - longint'(a.sample_y);
    mx = (dx < 0) ? 256'(-dx) : 256'(dx);
    my = (dy < 0) ? 256'(-dy) : 256'(dy);
    sum = mx * mx + my * my;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (256'd1 << b);
      if (t * t <= sum) r = t;
    end
    vx = a.vel_x;
    vy = a.vel_y;
    px = a.pos_x;
    py = a.pos_y;
    o.too_close = (r == 0);
    if (r != 0) begin
      vx = sat32(vx + gravity_accel(dx, a.strength, r));
      vy = sat32(vy + gravity_accel(dy, a.strength, r));
      px = sat32(px + vx);
      py = sat32(py + vy);
    end
    o.new_pos_x = px[31:0];
    o.new_pos_y = py[31:0];
    o.new_vel_x = vx[31:0];
    o.new_vel_y = vy[31:0];
    return o;
  endfunction

  task automatic send_particle(input gps_pkg::in_t item);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_states.insert(expected_states.size(), gravity_step(item));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", out_data);
      end else begin
        gps_pkg::out_t e;
        e = expected_states.pop_front();
        if (e !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      out_stall_left <= 0;
    end else if (out_stall_left > 0) begin
      out_stall <= 1'b1;
      out_stall_left <= out_stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      out_stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("** gravity_particle_step: FAILED **");
      $finish;
    end
  end

  function automatic gps_pkg::in_t make_item(input int mode);
    gps_pkg::in_t a;
    a.sample_x = $urandom;
    a.sample_y = $urandom;
    a.pos_x = $urandom;
    a.pos_y = $urandom;
    a.vel_x = $urandom;
    a.vel_y = $urandom;
    a.attractor_x = 16'($urandom);
    a.attractor_y = 16'($urandom);
    a.strength = $urandom;
    case (mode)
      0: begin
        a.sample_x = {a.attractor_x, 16'h0} + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        a.sample_y = {a.attractor_y, 16'h0} + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        a.pos_x = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        a.pos_y = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        a.vel_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        a.vel_y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        a.strength = $urandom_range(0, 1 << 24);
      end
      1: begin
        a.sample_x = {a.attractor_x, 16'h0} + $signed($urandom_range(0, 8)) - 4;
        a.sample_y = {a.attractor_y, 16'h0} + $signed($urandom_range(0, 8)) - 4;
      end
      2: begin
        a.sample_x = {a.attractor_x, 16'h0};
        a.sample_y = {a.attractor_y, 16'h0};
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic test_directed;
    gps_pkg::in_t a;
    for (int k = 0; k < 20; k++) begin
      a = make_item(3);
      case (k)
        0: begin a = make_item(2); end
        1: begin a = make_item(2); a.attractor_x = 16'sh8000; a.sample_x = 32'sh80000000; end
        2: begin a.strength = '0; end
        3: begin a.strength = '1; a = make_item(1); a.strength = '1; end
        4: begin
          a.attractor_x = 16'sh7FFF; a.sample_x = 32'sh80000000;
          a.attractor_y = 16'sh7FFF; a.sample_y = 32'sh80000000; a.strength = '1;
        end
        5: begin
          a.attractor_x = 16'sh8000; a.sample_x = 32'sh7FFFFFFF;
          a.attractor_y = 16'sh8000; a.sample_y = 32'sh7FFFFFFF; a.strength = '1;
        end
        6: begin a.vel_x = 32'sh7FFFFFFF; a.pos_x = 32'sh7FFFFFFF; a.strength = '0; end
        7: begin a.vel_y = 32'sh80000000; a.pos_y = 32'sh80000000; a.strength = '0; end
        8: begin a.sample_x = {a.attractor_x, 16'h0}; end
        9: begin a.sample_y = {a.attractor_y, 16'h0}; end
        10: begin a = make_item(1); a.vel_x = 32'sh7FFFFFFF; a.vel_y = 32'sh80000000; end
        11: begin a = make_item(0); a.strength = 32'h00010000; end
        default: a = make_item(k % 3);
      endcase
      send_particle(a);
    end
  endtask

  task automatic test_random(input int n);
    int m;
    for (int k = 0; k < n; k++) begin
      m = $urandom_range(0, 9);
      send_particle(make_item(m < 5 ? 0 : (m < 7 ? 1 : (m < 8 ? 2 : 3))));
    end
  endtask

  task automatic drain_results;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    idle_on = 1'b1;
    mismatches = 0;
    cycles = 0;
    out_stall_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1330);
    idle_on = 1'b0;
    test_random(300);
    in_valid <= 1'b0;
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("** gravity_particle_step: PASSED **");
    end else begin
      $display("** gravity_particle_step: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
design/gps_pkg.sv
design/gps_front.sv
design/gps_sqrt.sv
design/gps_accel.sv
design/gravity_particle_step.sv
design/gps_checker.sv
sim/tb_gravity_particle_step.sv
